// File: hdl/rrbm_pkg.sv
// Shared constants, result codes and RAM index helpers for the bank mapper.
package rrbm_pkg;

  localparam int RAM_BANKS      = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BYTES = 16384;

  localparam int RAM_DEPTH  = RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_IDX_W  = $clog2(RAM_DEPTH);
  localparam int RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
  localparam int ROM_OFF_W  = $clog2(ROM_BANK_BYTES);
  localparam int OFF_STEPS  = 8192 / RAM_BANK_BYTES;
  localparam int BANK_STEPS = 3 / RAM_BANKS;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_ADDR_W = 21;
  localparam int LOW_BANK_W = 5;
  localparam int UPPER_W    = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PADDR_W-1:0] REG_MAPPER_KIND = 3'd0;
  localparam logic [PADDR_W-1:0] REG_HAS_RAM     = 3'd4;

  typedef enum logic [1:0] {
    ST_ROM     = 2'd0,
    ST_RAM     = 2'd1,
    ST_WRITE   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  // Offset within a RAM bank: wrap a 13-bit window offset modulo the bank size.
  function automatic logic [RAM_OFF_W-1:0] ram_offset(input logic [12:0] off);
    logic [13:0] v;
    v = {1'b0, off};
    for (int i = 0; i < OFF_STEPS; i++) begin
      if (v >= 14'(RAM_BANK_BYTES)) begin
        v = v - 14'(RAM_BANK_BYTES);
      end
    end
    return v[RAM_OFF_W-1:0];
  endfunction

  // Bank number wrapped modulo the number of fitted RAM banks.
  function automatic logic [1:0] ram_bank(input logic [1:0] bank);
    logic [1:0] v;
    v = bank;
    for (int i = 0; i < BANK_STEPS; i++) begin
      if (v >= 2'(RAM_BANKS)) begin
        v = v - 2'(RAM_BANKS);
      end
    end
    return v;
  endfunction

  function automatic logic [RAM_IDX_W-1:0] ram_index(input logic [1:0] bank,
                                                     input logic [12:0] off);
    return RAM_IDX_W'(RAM_IDX_W'(ram_bank(bank)) * RAM_IDX_W'(RAM_BANK_BYTES))
         + RAM_IDX_W'(ram_offset(off));
  endfunction

endpackage

// File: hdl/rom_ram_bank_mapper.sv
// Bank mapper: decodes CPU bus beats into ROM offsets, RAM data and register writes.
//
// Input channel: in_valid / in_stall carry one bus beat (command, address,
// write_data). Output channel: out_valid / out_stall carry one result beat
// (status, rom_address, read_data) for every input beat, in order.
// A beat is taken at a rising edge with valid high and stall low.
// A beat taken at one edge shows its result after that edge. Throughput is
// one beat per cycle while in_stall is low; the decode, mapper register update
// and the single synchronous cartridge RAM access all happen at the taking edge.
// The result register holds while out_stall is high; in_stall rises only when
// a result is held and the next one cannot move on.
// Reset (rst, synchronous) drops any pending result, sets mapper_kind and
// has_ram to 1, disables RAM, sets low bank to 1, upper bits and mode to 0.
// RAM contents are not cleared; a byte never written reads as garbage.
// The APB port writes mapper_kind at address 0 and has_ram at address 4;
// write it only while the block is idle.
module rom_ram_bank_mapper
  import rrbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [ADDR_W-1:0]     address,
  input  logic [DATA_W-1:0]     write_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [ROM_ADDR_W-1:0] rom_address,
  output logic [DATA_W-1:0]     read_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  logic                  mapper_kind;
  logic                  has_ram;
  logic                  ram_enabled;
  logic [LOW_BANK_W-1:0] low_bank;
  logic [UPPER_W-1:0]    upper_bits;
  logic                  banking_mode;

  logic                  ram_enabled_next;
  logic [LOW_BANK_W-1:0] low_bank_next;
  logic [UPPER_W-1:0]    upper_bits_next;
  logic                  banking_mode_next;

  status_t               status_q;
  status_t               status_next;
  logic [ROM_ADDR_W-1:0] rom_q;
  logic [ROM_ADDR_W-1:0] rom_next;
  logic [DATA_W-1:0]     rd_q;

  logic [DATA_W-1:0]     mem [RAM_DEPTH];
  logic [RAM_IDX_W-1:0]  ram_idx;
  logic                  mem_we;

  logic                  accept;
  logic                  cfg_write;
  logic                  ram_ok;
  logic [LOW_BANK_W-1:0] wr_bank;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  assign ram_ok  = (address[15:13] == 3'b101) && has_ram && ram_enabled;
  assign ram_idx = ram_index(banking_mode ? upper_bits : 2'b00, address[12:0]);
  assign wr_bank = write_data[LOW_BANK_W-1:0];

  always_comb begin
    status_next       = ST_IGNORED;
    rom_next          = '0;
    mem_we            = 1'b0;
    ram_enabled_next  = ram_enabled;
    low_bank_next     = low_bank;
    upper_bits_next   = upper_bits;
    banking_mode_next = banking_mode;
    if (!mapper_kind) begin
      if (!command && !address[15]) begin
        status_next = ST_ROM;
        rom_next    = ROM_ADDR_W'(address);
      end
    end else if (!command) begin
      if (!address[15]) begin
        status_next = ST_ROM;
        if (!address[14]) begin
          rom_next = ROM_ADDR_W'(address);
        end else begin
          rom_next = {upper_bits, low_bank, address[ROM_OFF_W-1:0]};
        end
      end else if (ram_ok) begin
        status_next = ST_RAM;
      end
    end else begin
      unique case (address[15:13])
        3'b000: begin
          ram_enabled_next = (write_data[3:0] == 4'hA);
          status_next      = ST_WRITE;
        end
        3'b001: begin
          low_bank_next = (wr_bank == '0) ? LOW_BANK_W'(1) : wr_bank;
          status_next   = ST_WRITE;
        end
        3'b010: begin
          upper_bits_next = write_data[UPPER_W-1:0];
          status_next     = ST_WRITE;
        end
        3'b011: begin
          banking_mode_next = write_data[0];
          status_next       = ST_WRITE;
        end
        3'b101: begin
          if (ram_ok) begin
            mem_we      = 1'b1;
            status_next = ST_WRITE;
          end
        end
        default: begin
          status_next = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind  <= 1'b1;
      has_ram      <= 1'b1;
      ram_enabled  <= 1'b0;
      low_bank     <= LOW_BANK_W'(1);
      upper_bits   <= '0;
      banking_mode <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr)
          REG_MAPPER_KIND: mapper_kind <= pwdata[0];
          REG_HAS_RAM:     has_ram     <= pwdata[0];
          default:         ;
        endcase
      end
      if (accept) begin
        ram_enabled  <= ram_enabled_next;
        low_bank     <= low_bank_next;
        upper_bits   <= upper_bits_next;
        banking_mode <= banking_mode_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      rom_q    <= rom_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[ram_idx] <= write_data;
    end
    if (accept) begin
      rd_q <= mem[ram_idx];
    end
  end

  always_comb begin
    unique case (paddr)
      REG_MAPPER_KIND: prdata = PDATA_W'(mapper_kind);
      REG_HAS_RAM:     prdata = PDATA_W'(has_ram);
      default:         prdata = '0;
    endcase
  end

  assign status      = status_q;
  assign rom_address = rom_q;
  assign read_data   = (status_q == ST_RAM) ? rd_q : '0;

endmodule
